FILE: rtl/srtc_pkg.sv
// Package for the serial RTC date/time reader: sequencer phases, pin codes,
// byte indices, port widths and the BCD helper. No dependencies.
package srtc_pkg;

  // Sequencer phases of one read.
  typedef enum logic [3:0] {
    PH_INIT    = 4'd0,
    PH_DIRHOLD = 4'd1,
    PH_CSLO    = 4'd2,
    PH_CSHI    = 4'd3,
    PH_SLO     = 4'd4,
    PH_SHI     = 4'd5,
    PH_STAIL   = 4'd6,
    PH_RLO     = 4'd7,
    PH_RHI     = 4'd8,
    PH_RTAIL   = 4'd9
  } srtc_phase_e;

  // Pin codes: bit 2 chip select, bit 1 data out, bit 0 serial clock.
  localparam logic [2:0] PINS_CS_FRAME  = 3'b011;
  localparam logic [2:0] PINS_CS_HIGH   = 3'b111;
  localparam logic [2:0] PINS_READ_HIGH = 3'b101;
  localparam logic [2:0] PINS_READ_LOW  = 3'b100;

  localparam logic [7:0] CMD_DATETIME   = 8'h65;
  localparam logic [7:0] BIT7_MASK      = 8'h7F;
  localparam logic [3:0] NIBBLE_MASK    = 4'hF;
  localparam logic [7:0] HOLD_RESET     = 8'd8;
  localparam logic [7:0] WEEKDAY_MAX    = 8'd7;

  // Bytes of one read, in the order the chip sends them.
  localparam int unsigned NumBytes      = 7;
  localparam int unsigned NumStored     = NumBytes - 1;
  localparam logic [2:0]  IDX_YEAR      = 3'd0;
  localparam logic [2:0]  IDX_WEEKDAY   = 3'd3;
  localparam logic [2:0]  IDX_HOUR      = 3'd4;
  localparam logic [2:0]  IDX_LAST      = 3'(NumBytes - 1);
  localparam logic [2:0]  BIT_LAST      = 3'd7;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 72;

  // Converts a two-digit BCD byte to binary; digits above 9 are taken as is.
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, v[7:4] & NIBBLE_MASK};
    lo = {4'd0, v[3:0] & NIBBLE_MASK};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

FILE: rtl/serial_rtc_datetime_reader.sv
// Top level of the serial RTC date/time reader: pin sequencer, byte capture,
// BCD decode and the result register. Depends on srtc_pkg.
//
// Each input request is one timing tick (tuser 0) or a start command (tuser 1)
// and yields exactly one result request in the next cycle, so the block takes
// one request per clock cycle whenever the result side is ready; the only
// register between the two sides is the result register. The result shows
// the pin levels after the tick; on the tick that samples the last bit of the
// seventh byte tuser is 1 and tdata also carries the decoded date and time,
// the validity flag and the checksum. Every pin state is held for hold_ticks
// ticks (0 acts as 1). Bytes are decoded as they arrive and the checksum is
// summed on the fly, so the final result needs only one byte of decode.
module serial_rtc_datetime_reader (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input requests.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [srtc_pkg::InDataW-1:0]   s_axis_tdata,  // [0] sio_in, rest zero
  input  logic                           s_axis_tuser,  // [0] kind
  // Result requests.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] pins, [3] sio_drive, [4] valid_res, [12:5] year, [20:13] month,
  // [28:21] day, [36:29] weekday, [43:37] hour, [51:44] minute,
  // [58:52] second, [66:59] checksum, rest zero
  output logic [srtc_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tuser,  // [0] done_res
  // Configuration.
  input  logic                           cfg_we_i,
  input  logic [7:0]                     cfg_wdata_i   // hold_ticks
);
  import srtc_pkg::*;

  logic [7:0]  hold_ticks_q;
  logic        busy_q, busy_d;
  srtc_phase_e phase_q, phase_d;
  logic [7:0]  hold_q, hold_d;
  logic [2:0]  bit_q, bit_d;
  logic [2:0]  byte_q, byte_d;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  pins_q, pins_d;
  logic        drive_q, drive_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  dec_q [NumStored];

  logic        accept;
  logic        kind;
  logic        sio;
  logic [7:0]  rx_byte;
  logic [7:0]  rx_dec;
  logic        capture;
  logic        done;
  logic [6:0]  second;
  logic        ok;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic                m_user_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser;
  assign sio           = s_axis_tdata[0];

  // Byte being assembled, including the bit sampled on this tick.
  assign rx_byte = {sio, shift_q[7:1]};
  assign rx_dec  = (byte_q == IDX_HOUR || byte_q == IDX_LAST) ?
                   bcd_to_bin(rx_byte & BIT7_MASK) : bcd_to_bin(rx_byte);

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    hold_d  = hold_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    pins_d  = pins_q;
    drive_d = drive_q;
    sum_d   = sum_q;
    capture = 1'b0;
    done    = 1'b0;
    if (accept) begin
      if (kind) begin
        if (!busy_q) begin
          busy_d  = 1'b1;
          drive_d = 1'b1;
          bit_d   = '0;
          byte_d  = '0;
          shift_d = '0;
          sum_d   = '0;
          phase_d = PH_INIT;
          pins_d  = PINS_CS_FRAME;
          hold_d  = hold_ticks_q;
        end
      end else if (busy_q) begin
        if (hold_q > 8'd1) begin
          hold_d = hold_q - 8'd1;
        end else begin
          hold_d = hold_ticks_q;
          unique case (phase_q)
            PH_INIT: begin
              drive_d = 1'b1;
              phase_d = PH_DIRHOLD;
            end
            PH_DIRHOLD: begin
              phase_d = PH_CSLO;
              pins_d  = PINS_CS_FRAME;
            end
            PH_CSLO: begin
              phase_d = PH_CSHI;
              pins_d  = PINS_CS_HIGH;
            end
            PH_CSHI: begin
              shift_d = CMD_DATETIME;
              bit_d   = '0;
              phase_d = PH_SLO;
              pins_d  = {1'b1, CMD_DATETIME[7], 1'b0};
            end
            PH_SLO: begin
              phase_d = PH_SHI;
              pins_d  = pins_q | 3'b001;
            end
            PH_SHI: begin
              shift_d = {shift_q[6:0], 1'b0};
              if (bit_q == BIT_LAST) begin
                phase_d = PH_STAIL;
              end else begin
                bit_d   = bit_q + 3'd1;
                phase_d = PH_SLO;
                pins_d  = {1'b1, shift_q[6], 1'b0};
              end
            end
            PH_STAIL: begin
              drive_d = 1'b0;
              byte_d  = '0;
              bit_d   = '0;
              shift_d = '0;
              phase_d = PH_RLO;
              pins_d  = PINS_READ_LOW;
            end
            PH_RLO: begin
              phase_d = PH_RHI;
              pins_d  = PINS_READ_HIGH;
            end
            PH_RHI: begin
              shift_d = rx_byte;
              if (bit_q == BIT_LAST) begin
                if (byte_q >= IDX_LAST) begin
                  busy_d  = 1'b0;
                  phase_d = PH_INIT;
                  hold_d  = '0;
                  done    = 1'b1;
                end else begin
                  capture = 1'b1;
                  if (byte_q != IDX_WEEKDAY) begin
                    sum_d = sum_q + rx_dec;
                  end
                  phase_d = PH_RTAIL;
                end
              end else begin
                bit_d   = bit_q + 3'd1;
                phase_d = PH_RLO;
                pins_d  = PINS_READ_LOW;
              end
            end
            PH_RTAIL: begin
              byte_d  = byte_q + 3'd1;
              bit_d   = '0;
              shift_d = '0;
              phase_d = PH_RLO;
              pins_d  = PINS_READ_LOW;
            end
            default: begin
              busy_d  = 1'b0;
              phase_d = PH_INIT;
              hold_d  = '0;
            end
          endcase
        end
      end
    end
  end

  // The last byte is the second; it is decoded here and never stored.
  assign second = rx_dec[6:0];
  assign ok = dec_q[0] != '0 && dec_q[1] != '0 && dec_q[2] != '0 &&
              dec_q[IDX_WEEKDAY] <= WEEKDAY_MAX;

  always_comb begin
    m_data_d      = '0;
    m_data_d[2:0] = pins_d;
    m_data_d[3]   = drive_d;
    if (done) begin
      m_data_d[4]     = ok;
      m_data_d[12:5]  = dec_q[IDX_YEAR];
      m_data_d[20:13] = dec_q[1];
      m_data_d[28:21] = dec_q[2];
      m_data_d[36:29] = dec_q[IDX_WEEKDAY];
      m_data_d[43:37] = dec_q[IDX_HOUR][6:0];
      m_data_d[51:44] = dec_q[5];
      m_data_d[58:52] = second;
      m_data_d[66:59] = sum_q + {1'b0, second};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HOLD_RESET;
      busy_q       <= 1'b0;
      phase_q      <= PH_INIT;
      hold_q       <= '0;
      bit_q        <= '0;
      byte_q       <= '0;
      shift_q      <= '0;
      pins_q       <= '0;
      drive_q      <= 1'b0;
      sum_q        <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hold_ticks_q <= cfg_wdata_i;
      end
      busy_q  <= busy_d;
      phase_q <= phase_d;
      hold_q  <= hold_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      pins_q  <= pins_d;
      drive_q <= drive_d;
      sum_q   <= sum_d;
      if (accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Decoded bytes and the result payload need no reset.
  always_ff @(posedge clk_i) begin
    if (capture) begin
      dec_q[byte_q] <= (byte_q == IDX_HOUR) ? {1'b0, rx_dec[6:0]} : rx_dec;
    end
    if (accept) begin
      m_data_q <= m_data_d;
      m_user_q <= done;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: rtl/srtc_chk.sv
// Port-level checker for serial_rtc_datetime_reader and its bind statement.
// Depends on srtc_pkg.
module srtc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [srtc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import srtc_pkg::*;

  // A completed read always leaves the clock high and the data pin released.
  a_done_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[2:0] == PINS_READ_HIGH && !m_axis_tdata[3])
    else $error("completed read with wrong pin state");

  // Outside a completed read all decoded fields are zero.
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OutDataW-1:4] == '0)
    else $error("decoded fields set without a completed read");

  // A valid date never has a zero year.
  a_valid_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[4] |-> m_axis_tdata[12:5] != '0)
    else $error("valid flag with zero year");

  // An empty result register never blocks the input side.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind serial_rtc_datetime_reader srtc_chk u_srtc_chk (.*);

FILE: tb/serial_rtc_datetime_reader_tb.sv
// Testbench for serial_rtc_datetime_reader: drives tick and start requests, predicts
// pins and decoded date/time per request, and checks every result request.
// Depends on srtc_pkg and the serial_rtc_datetime_reader RTL.
`timescale 1ns / 100ps

module serial_rtc_datetime_reader_tb;
  import srtc_pkg::*;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned ResetHoldTicks = 40;
  localparam int unsigned MaxReports     = 100;

  typedef struct packed {
    logic [2:0] pins;
    logic       drive;
    logic       done;
    logic       ok;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] weekday;
    logic [6:0] hour;
    logic [7:0] minute;
    logic [6:0] second;
    logic [7:0] checksum;
  } rtc_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [0] sio_in, rest zero
  logic                s_axis_tuser = 1'b0; // [0] kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // pins, sio_drive, valid_res, date, checksum
  logic                m_axis_tuser;        // [0] done_res
  logic                cfg_we_i = 1'b0;
  logic [7:0]          cfg_wdata_i = HOLD_RESET;

  // Predicted sequencer state.
  logic        seq_busy;
  srtc_phase_e seq_phase;
  logic [7:0]  hold_cfg;
  logic [7:0]  hold_left;
  logic [2:0]  bit_idx;
  logic [2:0]  byte_idx;
  logic [7:0]  shreg;
  logic [2:0]  pins_q;
  logic        drive_q;
  logic [7:0]  captured [NumBytes];

  logic [7:0]  date_bytes [NumBytes];  // what the emulated chip answers
  rtc_result_t pending_results [$];
  int unsigned errors = 0;
  logic        steady = 1'b0;          // no idling on either side while set

  serial_rtc_datetime_reader i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 24);
  end

  function automatic logic [7:0] bcd_value(input logic [7:0] v);
    return 8'(10 * v[7:4] + v[3:0]);
  endfunction

  function automatic void load_state(input srtc_phase_e ph, input logic [2:0] pins);
    seq_phase = ph;
    pins_q = pins;
    hold_left = hold_cfg;
  endfunction

  function automatic logic [2:0] command_pins();
    return PINS_READ_LOW | {1'b0, shreg[7], 1'b0};
  endfunction

  // One pin-state step of the sequencer; returns 1 when the last bit is sampled.
  function automatic logic seq_advance(input logic sio);
    case (seq_phase)
      PH_INIT: begin
        drive_q = 1'b1;
        load_state(PH_DIRHOLD, pins_q);
      end
      PH_DIRHOLD: load_state(PH_CSLO, PINS_CS_FRAME);
      PH_CSLO:    load_state(PH_CSHI, PINS_CS_HIGH);
      PH_CSHI: begin
        shreg = CMD_DATETIME;
        bit_idx = '0;
        load_state(PH_SLO, command_pins());
      end
      PH_SLO: load_state(PH_SHI, pins_q | 3'b001);
      PH_SHI: begin
        shreg = shreg << 1;
        if (bit_idx == BIT_LAST) begin
          load_state(PH_STAIL, pins_q);
        end else begin
          bit_idx++;
          load_state(PH_SLO, command_pins());
        end
      end
      PH_STAIL: begin
        drive_q = 1'b0;
        byte_idx = '0;
        bit_idx = '0;
        shreg = '0;
        load_state(PH_RLO, PINS_READ_LOW);
      end
      PH_RLO: load_state(PH_RHI, PINS_READ_HIGH);
      PH_RHI: begin
        shreg = {sio, shreg[7:1]};
        if (bit_idx == BIT_LAST) begin
          captured[byte_idx] = shreg;
          if (byte_idx >= IDX_LAST) begin
            // The read ends at once; pins keep their last levels.
            seq_busy = 1'b0;
            seq_phase = PH_INIT;
            hold_left = '0;
            return 1'b1;
          end
          load_state(PH_RTAIL, pins_q);
        end else begin
          bit_idx++;
          load_state(PH_RLO, PINS_READ_LOW);
        end
      end
      PH_RTAIL: begin
        byte_idx++;
        bit_idx = '0;
        shreg = '0;
        load_state(PH_RLO, PINS_READ_LOW);
      end
      default: begin
        seq_busy = 1'b0;
        seq_phase = PH_INIT;
        hold_left = '0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic rtc_result_t predict_result(input logic kind, input logic sio);
    rtc_result_t r;
    logic        done;
    done = 1'b0;
    if (kind == KIND_START) begin
      // A start while a read is running is dropped.
      if (!seq_busy) begin
        seq_busy = 1'b1;
        drive_q = 1'b1;
        bit_idx = '0;
        byte_idx = '0;
        shreg = '0;
        load_state(PH_INIT, PINS_CS_FRAME);
      end
    end else if (seq_busy) begin
      if (hold_left > 1) hold_left--;
      else done = seq_advance(sio);
    end
    r = '0;
    r.pins = pins_q;
    r.drive = drive_q;
    if (done) begin
      r.done = 1'b1;
      r.year = bcd_value(captured[0]);
      r.month = bcd_value(captured[1]);
      r.day = bcd_value(captured[2]);
      r.weekday = bcd_value(captured[3]);
      r.hour = 7'(bcd_value(captured[4] & BIT7_MASK));
      r.minute = bcd_value(captured[5]);
      r.second = 7'(bcd_value(captured[6] & BIT7_MASK));
      r.ok = (r.year != 0) && (r.month != 0) && (r.day != 0) && (r.weekday <= WEEKDAY_MAX);
      r.checksum = 8'(r.year + r.month + r.day + r.hour + r.minute + r.second);
    end
    return r;
  endfunction

  // Sends one request and records its expected result once it is accepted.
  task automatic send_req(input logic kind, input logic sio);
    if (!steady) begin
      while ($urandom_range(99) < 24) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW - 1){1'b0}}, sio};
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_result(kind, sio));
  endtask

  // A tick that answers the chip's data bit whenever the next step samples it.
  task automatic send_tick();
    logic sio;
    if (seq_busy && seq_phase == PH_RHI && hold_left <= 1) sio = date_bytes[byte_idx][bit_idx];
    else sio = 1'($urandom_range(1));
    send_req(KIND_TICK, sio);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_hold(input logic [7:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hold_cfg = value;
  endtask

  // One complete read of date_bytes; with noise, stray starts are mixed in.
  task automatic run_read(input logic noisy);
    send_req(KIND_START, 1'($urandom_range(1)));
    while (seq_busy) begin
      if (noisy && $urandom_range(39) == 0) send_req(KIND_START, 1'($urandom_range(1)));
      else send_tick();
    end
    repeat ($urandom_range(2)) send_tick();
  endtask

  task automatic test_idle_ticks();
    send_req(KIND_TICK, 1'b0);
    send_req(KIND_TICK, 1'b1);
  endtask

  task automatic test_reset_hold_read();
    date_bytes = '{8'h24, 8'h12, 8'h31, 8'h07, 8'h23, 8'h59, 8'h59};
    send_req(KIND_START, 1'b0);
    send_req(KIND_START, 1'b1);
    // The reset hold covers the chip-select frame and the first command bit.
    repeat (ResetHoldTicks) send_tick();
    set_hold(8'd1);
    while (seq_busy) send_tick();
    // Pins hold clock high with the data pin released after the read.
    test_idle_ticks();
  endtask

  task automatic test_hold_zero();
    set_hold(8'd0);
    date_bytes = '{default: 8'hFF};
    run_read(1'b1);
  endtask

  task automatic test_invalid_dates();
    set_hold(8'd1);
    date_bytes = '{8'h99, 8'h09, 8'h30, 8'h08, 8'h92, 8'h45, 8'hD9};
    run_read(1'b0);
  endtask

  task automatic test_hold_max();
    set_hold(8'd255);
    date_bytes = '{8'h99, 8'h12, 8'h28, 8'h00, 8'h23, 8'h59, 8'h80};
    send_req(KIND_START, 1'b0);
    // The first pin state keeps the full maximum hold; the rest runs at hold 1.
    set_hold(8'd1);
    while (seq_busy) send_tick();
  endtask

  task automatic test_random_reads();
    int unsigned pick;
    set_hold(8'($urandom_range(1)));
    for (int i = 0; i < NumBytes; i++) begin
      pick = $urandom_range(15);
      if (pick < 10) date_bytes[i] = {4'($urandom_range(9)), 4'($urandom_range(9))};
      else if (pick < 12) date_bytes[i] = 8'h00;
      else if (pick < 14) date_bytes[i] = 8'($urandom_range(255));
      else if (pick == 14) date_bytes[i] = 8'hFF;
      else if (i == IDX_WEEKDAY) date_bytes[i] = 8'($urandom_range(8, 7));
      else date_bytes[i] = 8'h80 | 8'($urandom_range(127));
    end
    steady = 1'b1;
    run_read(1'b1);
    steady = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MaxReports) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    rtc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports) $error("result request with no expected result waiting");
      end else begin
        want = pending_results.pop_front();
        check_field("pins", 8'(want.pins), 8'(m_axis_tdata[2:0]));
        check_field("sio_drive", 8'(want.drive), 8'(m_axis_tdata[3]));
        check_field("done_res", 8'(want.done), 8'(m_axis_tuser));
        check_field("valid_res", 8'(want.ok), 8'(m_axis_tdata[4]));
        check_field("year", want.year, m_axis_tdata[12:5]);
        check_field("month", want.month, m_axis_tdata[20:13]);
        check_field("day", want.day, m_axis_tdata[28:21]);
        check_field("weekday", want.weekday, m_axis_tdata[36:29]);
        check_field("hour", 8'(want.hour), 8'(m_axis_tdata[43:37]));
        check_field("minute", want.minute, m_axis_tdata[51:44]);
        check_field("second", 8'(want.second), 8'(m_axis_tdata[58:52]));
        check_field("checksum", want.checksum, m_axis_tdata[66:59]);
        check_field("padding", '0, 8'(m_axis_tdata[OutDataW-1:67]));
      end
    end
  end

  // Ends the run when neither side has moved a request for too long.
  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stalled = 0;
      else
        stalled++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    seq_busy = 1'b0;
    seq_phase = PH_INIT;
    hold_cfg = HOLD_RESET;
    hold_left = '0;
    bit_idx = '0;
    byte_idx = '0;
    shreg = '0;
    pins_q = '0;
    drive_q = 1'b0;
    date_bytes = '{default: 8'h00};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_reset_hold_read();
    test_hold_zero();
    test_invalid_dates();
    test_hold_max();
    test_random_reads();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
